// File: design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: design/pmcd_pkg.sv
package pmcd_pkg;

	localparam int WINDOW_SIZE   = 5;
	localparam int PATTERN_COUNT = 7;
	localparam int MEDIAN_RANK   = WINDOW_SIZE / 2;
	localparam int SLOT_W        = $clog2(WINDOW_SIZE);
	localparam int CNT_W         = $clog2(WINDOW_SIZE + 1);

	localparam logic [15:0] MIN_PULSE_RESET = 16'd1;
	localparam logic [15:0] MAX_PULSE_RESET = 16'd4080;

	localparam logic REG_MIN_PULSE = 1'b0;
	localparam logic REG_MAX_PULSE = 1'b1;

	localparam logic [7:0] CMD_PATTERN = 8'd255;
	localparam logic [7:0] CMD_TOGGLE  = 8'd254;
	localparam logic [7:0] CMD_DIMMER  = 8'd253;
	localparam logic [7:0] DIM_STEP    = 8'd50;
	localparam logic [7:0] FULL_BRIGHT = 8'd255;

	localparam logic [1:0] MODE_IDLE    = 2'd0;
	localparam logic [1:0] MODE_PATTERN = 2'd1;
	localparam logic [1:0] MODE_BLUE    = 2'd2;
	localparam logic [1:0] MODE_DARK    = 2'd3;

	typedef logic [7:0] level_t;

endpackage

// File: design/pwm_median_command_decoder.sv
// Pulse-width command decoder. A pulse width is taken when in_valid is high and in_stall low;
// it is mapped onto 0..255 between the configured minimum and maximum widths, inverted, put
// into a five-entry window, and the window median is decoded as a command. A transaction runs
// from acceptance until out_valid rises through a setup step, the quotient-bit steps of the
// restoring divider, a window write, one rank step of the median compare row per window entry
// and a command step. The divider is skipped when the range is empty, the pulse is at or
// below the minimum or the value is known to clamp. in_stall is high during that work, so
// the block takes no new pulse until it is through with the last one. The result sits in
// an output register, so the next pulse can be accepted while it waits; only the command
// step waits for that register to be free, which adds the cycles that the previous result
// is held by out_stall. The registers may be written only while no transaction is in
// flight.
module pwm_median_command_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [19:0] pulse_width,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  filtered_value,
	output logic        value_changed,
	output logic [1:0]  led_mode,
	output logic [2:0]  pattern_number,
	output logic [7:0]  applied_brightness,
	output logic        pattern_restart
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PREP = 3'd1;
	localparam logic [2:0] S_DIV  = 3'd2;
	localparam logic [2:0] S_INS  = 3'd3;
	localparam logic [2:0] S_MED  = 3'd4;
	localparam logic [2:0] S_CMD  = 3'd5;

	logic [2:0]  state_q;
	logic [15:0] min_q;
	logic [15:0] max_q;
	logic [19:0] width_q;
	logic [23:0] rem_q;
	logic [22:0] dvs_q;
	logic [2:0]  step_q;
	pmcd_pkg::level_t quo_q;

	pmcd_pkg::level_t win_q [pmcd_pkg::WINDOW_SIZE];
	logic [pmcd_pkg::SLOT_W-1:0] slot_q;
	logic [pmcd_pkg::SLOT_W-1:0] cand_q;
	pmcd_pkg::level_t med_q;

	pmcd_pkg::level_t prev_q;
	logic             prev_valid_q;
	logic             pat_on_q;
	logic             toggle_q;
	pmcd_pkg::level_t stored_q;
	pmcd_pkg::level_t shown_q;
	logic [1:0]       mode_q;
	logic [2:0]       pat_idx_q;

	logic             out_valid_q;
	pmcd_pkg::level_t out_value_q;
	logic             out_changed_q;
	logic [1:0]       out_mode_q;
	logic [2:0]       out_pat_q;
	pmcd_pkg::level_t out_bright_q;
	logic             out_restart_q;

	logic [15:0] range;
	logic        range_empty;
	logic        below_min;
	logic [19:0] diff;
	logic [27:0] scaled;
	logic        saturates;
	logic        div_fits;
	logic        slot_last;
	logic        cand_last;
	logic        out_free;

	pmcd_pkg::level_t cand_val;
	logic [pmcd_pkg::CNT_W-1:0] lt_cnt;
	logic [pmcd_pkg::CNT_W-1:0] le_cnt;
	logic                       is_median;

	logic             changed;
	logic             pat_on_d;
	logic             toggle_d;
	pmcd_pkg::level_t stored_d;
	pmcd_pkg::level_t shown_d;
	logic [1:0]       mode_d;
	logic [2:0]       pat_idx_d;

	assign range_empty = (max_q <= min_q);
	assign range       = max_q - min_q;
	assign below_min   = (width_q <= {4'd0, min_q});
	assign diff        = width_q - {4'd0, min_q};
	// Times 255 as a shift and a subtract.
	assign scaled      = {diff, 8'd0} - {8'd0, diff};
	assign saturates   = (scaled >= {4'd0, range, 8'd0});
	assign div_fits    = (rem_q >= {1'b0, dvs_q});
	assign slot_last   = (slot_q == pmcd_pkg::SLOT_W'(pmcd_pkg::WINDOW_SIZE - 1));
	assign cand_last   = (cand_q == pmcd_pkg::SLOT_W'(pmcd_pkg::WINDOW_SIZE - 1));
	assign out_free    = !out_valid_q || !out_stall;

	// One rank row: the candidate is compared against every window entry at once.
	assign cand_val = win_q[cand_q];
	always_comb begin
		lt_cnt = '0;
		le_cnt = '0;
		for (int j = 0; j < pmcd_pkg::WINDOW_SIZE; j++) begin
			if (win_q[j] < cand_val) begin
				lt_cnt = lt_cnt + 1'b1;
			end
			if (win_q[j] <= cand_val) begin
				le_cnt = le_cnt + 1'b1;
			end
		end
	end
	assign is_median = (lt_cnt <= pmcd_pkg::CNT_W'(pmcd_pkg::MEDIAN_RANK)) &&
		(le_cnt > pmcd_pkg::CNT_W'(pmcd_pkg::MEDIAN_RANK));

	always_comb begin
		changed   = !prev_valid_q || (med_q != prev_q);
		pat_on_d  = pat_on_q;
		toggle_d  = toggle_q;
		stored_d  = stored_q;
		shown_d   = shown_q;
		mode_d    = mode_q;
		pat_idx_d = pat_idx_q;
		if (changed) begin
			priority if (med_q == pmcd_pkg::CMD_PATTERN) begin
				pat_on_d  = 1'b1;
				shown_d   = pmcd_pkg::FULL_BRIGHT;
				mode_d    = pmcd_pkg::MODE_PATTERN;
				pat_idx_d = (pat_idx_q == 3'(pmcd_pkg::PATTERN_COUNT - 1)) ? 3'd0 :
					pat_idx_q + 3'd1;
				toggle_d  = 1'b0;
			end else if (med_q == pmcd_pkg::CMD_TOGGLE) begin
				pat_on_d = 1'b0;
				if (toggle_q) begin
					shown_d = 8'd0;
					mode_d  = pmcd_pkg::MODE_DARK;
				end else begin
					shown_d = stored_q;
					mode_d  = pmcd_pkg::MODE_BLUE;
				end
				toggle_d = !toggle_q;
			end else if (med_q == pmcd_pkg::CMD_DIMMER && !pat_on_q) begin
				stored_d = stored_q - pmcd_pkg::DIM_STEP;
				shown_d  = stored_q - pmcd_pkg::DIM_STEP;
			end else begin
				shown_d = shown_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= pmcd_pkg::MIN_PULSE_RESET;
			max_q <= pmcd_pkg::MAX_PULSE_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				pmcd_pkg::REG_MIN_PULSE: min_q <= cfg_data;
				pmcd_pkg::REG_MAX_PULSE: max_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slot_q       <= '0;
			cand_q       <= '0;
			prev_q       <= '0;
			prev_valid_q <= 1'b0;
			pat_on_q     <= 1'b0;
			toggle_q     <= 1'b0;
			stored_q     <= pmcd_pkg::FULL_BRIGHT;
			shown_q      <= pmcd_pkg::FULL_BRIGHT;
			mode_q       <= pmcd_pkg::MODE_IDLE;
			pat_idx_q    <= '0;
			for (int i = 0; i < pmcd_pkg::WINDOW_SIZE; i++) begin
				win_q[i] <= '0;
			end
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_PREP;
					end
				end
				S_PREP: begin
					if (range_empty || below_min || saturates) begin
						state_q <= S_INS;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (step_q == 3'd0) begin
						state_q <= S_INS;
					end
				end
				S_INS: begin
					win_q[slot_q] <= ~quo_q;
					slot_q        <= slot_last ? '0 : slot_q + 1'b1;
					cand_q        <= '0;
					state_q       <= S_MED;
				end
				S_MED: begin
					cand_q <= cand_last ? '0 : cand_q + 1'b1;
					if (cand_last) begin
						state_q <= S_CMD;
					end
				end
				S_CMD: begin
					if (out_free) begin
						if (changed) begin
							prev_q       <= med_q;
							prev_valid_q <= 1'b1;
						end
						pat_on_q  <= pat_on_d;
						toggle_q  <= toggle_d;
						stored_q  <= stored_d;
						shown_q   <= shown_d;
						mode_q    <= mode_d;
						pat_idx_q <= pat_idx_d;
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath of the divider and the median search; no reset needed.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			width_q <= pulse_width;
		end
		if (state_q == S_PREP) begin
			rem_q  <= scaled[23:0];
			dvs_q  <= {range, 7'd0};
			step_q <= 3'd7;
			if (range_empty || below_min) begin
				quo_q <= 8'd0;
			end else if (saturates) begin
				quo_q <= 8'd255;
			end else begin
				quo_q <= 8'd0;
			end
		end
		if (state_q == S_DIV) begin
			if (div_fits) begin
				rem_q <= rem_q - {1'b0, dvs_q};
			end
			quo_q  <= {quo_q[6:0], div_fits};
			dvs_q  <= dvs_q >> 1;
			step_q <= step_q - 3'd1;
		end
		if (state_q == S_MED && is_median) begin
			med_q <= cand_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_CMD && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CMD && out_free) begin
			out_value_q   <= med_q;
			out_changed_q <= changed;
			out_mode_q    <= mode_d;
			out_pat_q     <= pat_idx_d;
			out_bright_q  <= shown_d;
			out_restart_q <= (med_q == pmcd_pkg::CMD_PATTERN);
		end
	end

	assign in_stall           = (state_q != S_IDLE);
	assign out_valid          = out_valid_q;
	assign filtered_value     = out_value_q;
	assign value_changed      = out_changed_q;
	assign led_mode           = out_mode_q;
	assign pattern_number     = out_pat_q;
	assign applied_brightness = out_bright_q;
	assign pattern_restart    = out_restart_q;

endmodule

// File: design/pmcd_checker.sv
`include "assert_macros.svh"

module pmcd_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] filtered_value,
	input logic [1:0] led_mode,
	input logic [2:0] pattern_number,
	input logic [7:0] applied_brightness,
	input logic       pattern_restart
);

	// A stalled result must not vanish, and its filtered value must not change.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(filtered_value))

	// The block works on one transaction at a time.
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall)

	`ASSERT_SAME(a_restart_flag, clk, arst_n, out_valid, pattern_restart == (filtered_value == pmcd_pkg::CMD_PATTERN))

	// Pattern mode always runs at full brightness, and dimming is locked out there.
	`ASSERT_SAME(a_pattern_bright, clk, arst_n, out_valid && led_mode == pmcd_pkg::MODE_PATTERN, applied_brightness == pmcd_pkg::FULL_BRIGHT)

	`ASSERT_SAME(a_pattern_range, clk, arst_n, out_valid, pattern_number < 3'(pmcd_pkg::PATTERN_COUNT))

endmodule

bind pwm_median_command_decoder pmcd_checker u_pmcd_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.in_valid           (in_valid),
	.in_stall           (in_stall),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.filtered_value     (filtered_value),
	.led_mode           (led_mode),
	.pattern_number     (pattern_number),
	.applied_brightness (applied_brightness),
	.pattern_restart    (pattern_restart)
);
